### design/bvs_pkg.sv
// Shared types, constants and key compare for the box volume shear sort.
package bvs_pkg;

    localparam int GRID_SIDE_DEF = 8;
    localparam int QDEPTH        = 4;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] len;
        logic [15:0] wid;
        logic [15:0] hgt;
        logic [47:0] vol;
    } t_box;

    // a sorts after b: larger volume, or equal volume and larger height
    function automatic logic key_gt(input t_box a, input t_box b);
        logic v_eq;
        v_eq = (a.vol == b.vol);
        return v_eq ? (a.hgt > b.hgt) : (a.vol > b.vol);
    endfunction

endpackage

### design/bvs_front.sv
// Front end: accepts boxes, forms volume over two multiply stages, credits the queue.
module bvs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [15:0]   i_box_id,
    input  logic [15:0]   i_length,
    input  logic [15:0]   i_width,
    input  logic [15:0]   i_height,
    input  logic          i_q_pop,
    output logic          o_full,
    output logic          o_q_push,
    output bvs_pkg::t_box o_q_data
);
    localparam int UW = $clog2(bvs_pkg::QDEPTH + 1);

    logic          r_v1, r_v2;
    logic [15:0]   r_id1, r_l1, r_w1, r_h1;
    logic [31:0]   r_p1;
    bvs_pkg::t_box r_box2;
    logic [UW-1:0] r_used, n_used;
    logic          accept;

    assign o_full   = (r_used == UW'(bvs_pkg::QDEPTH));
    assign accept   = i_push & ~o_full;
    assign o_q_push = r_v2;
    assign o_q_data = r_box2;

    // slots held by in-flight items plus queued items
    always_comb begin
        n_used = r_used + UW'(accept) - UW'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_used <= '0;
        end else begin
            r_v1   <= accept;
            r_v2   <= r_v1;
            r_used <= n_used;
        end
        r_id1      <= i_box_id;
        r_l1       <= i_length;
        r_w1       <= i_width;
        r_h1       <= i_height;
        r_p1       <= 32'(i_length) * 32'(i_width);
        r_box2.id  <= r_id1;
        r_box2.len <= r_l1;
        r_box2.wid <= r_w1;
        r_box2.hgt <= r_h1;
        r_box2.vol <= 48'(r_p1) * 48'(r_h1);
    end

endmodule

### design/bvs_queue.sv
// Short register queue between the front end and the sort engine.
module bvs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bvs_pkg::t_box i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output bvs_pkg::t_box o_data,
    output logic [$clog2(bvs_pkg::QDEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(bvs_pkg::QDEPTH);
    localparam int CW = $clog2(bvs_pkg::QDEPTH + 1);

    bvs_pkg::t_box r_mem [bvs_pkg::QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/bvs_back.sv
// Sort engine: grid of box cells, shift load, shear sort steps, shift out.
module bvs_back #(
    parameter int GRID_SIDE = bvs_pkg::GRID_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bvs_pkg::t_box i_q_data,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output bvs_pkg::t_box o_box,
    output logic          o_last
);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int NPH   = 1 + $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int PW    = $clog2(NPH);
    localparam int SW    = $clog2(GRID_SIDE);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    bvs_pkg::t_box r_cell   [CELLS];
    bvs_pkg::t_box n_sorted [CELLS];
    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_phase;
    logic [SW-1:0] r_step;
    logic          shift_en, emit_take;

    assign o_q_pop   = (r_state == ST_LOAD) & i_q_valid;
    assign o_empty   = (r_state != ST_EMIT);
    assign o_box     = r_cell[0];
    assign o_last    = (r_cnt == CW'(1));
    assign emit_take = (r_state == ST_EMIT) & i_pop;
    assign shift_en  = o_q_pop | emit_take;

    // one transposition step over every line of the grid
    always_comb begin
        for (int c = 0; c < CELLS; c++) begin
            n_sorted[c] = r_cell[c];
        end
        for (int ln = 0; ln < GRID_SIDE; ln++) begin
            for (int k = 0; k < GRID_SIDE - 1; k++) begin
                int   lo, hi;
                logic asc, sw;
                if (!r_phase[0]) begin
                    lo  = ln * GRID_SIDE + k;
                    hi  = lo + 1;
                    asc = (ln % 2 == 0);
                end else begin
                    lo  = k * GRID_SIDE + ln;
                    hi  = lo + GRID_SIDE;
                    asc = 1'b1;
                end
                sw = asc ? bvs_pkg::key_gt(r_cell[lo], r_cell[hi])
                         : bvs_pkg::key_gt(r_cell[hi], r_cell[lo]);
                if ((k % 2) == int'(r_step[0]) && sw) begin
                    n_sorted[lo] = r_cell[hi];
                    n_sorted[hi] = r_cell[lo];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_phase <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (o_q_pop) begin
                        if (r_cnt == CW'(CELLS - 1)) begin
                            r_state <= ST_SORT;
                            r_phase <= '0;
                            r_step  <= '0;
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SORT: begin
                    if (r_step == SW'(GRID_SIDE - 1)) begin
                        r_step <= '0;
                        if (r_phase == PW'(NPH - 1)) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_phase <= r_phase + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (i_pop) begin
                        r_cnt <= r_cnt - 1'b1;
                        if (o_last) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
        if (shift_en) begin
            for (int c = 0; c < CELLS - 1; c++) begin
                r_cell[c] <= r_cell[c+1];
            end
            r_cell[CELLS-1] <= i_q_data;
        end else if (r_state == ST_SORT) begin
            for (int c = 0; c < CELLS; c++) begin
                r_cell[c] <= n_sorted[c];
            end
        end
    end

endmodule

### design/box_volume_shear_sort.sv
// Top level of the box volume shear sort: front end, queue and sort engine.
// From last box in to first result out: the multiply stages, queue write and grid load,
// then the sort phases with one transposition step per cycle.
// Throughput: one box per cycle while loading and the queue holds one, one result per
// cycle while emitting and pop is high; new boxes only fill the queue during sort and emit.
// Reset: synchronous, active low; clears the load count, queue and handshakes.
module box_volume_shear_sort #(
    parameter int GRID_SIDE = bvs_pkg::GRID_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_box_id,
    input  logic [15:0] i_length,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_sorted_id,
    output logic [15:0] o_sorted_length,
    output logic [15:0] o_sorted_width,
    output logic [15:0] o_sorted_height,
    output logic [47:0] o_sorted_volume,
    output logic        o_last_result
);
    localparam int QCW = $clog2(bvs_pkg::QDEPTH + 1);

    // front-to-queue transfer
    logic           q_push;
    bvs_pkg::t_box  q_in;
    // queue-to-engine transfer
    logic           q_valid, q_pop;
    bvs_pkg::t_box  q_out;
    logic [QCW-1:0] q_count;
    bvs_pkg::t_box  res_box;

    // front end: multiplies out the volume; full is driven by a slot credit count
    bvs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_box_id (i_box_id),
        .i_length (i_length),
        .i_width  (i_width),
        .i_height (i_height),
        .i_q_pop  (q_pop),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    bvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    // engine: loads the grid, sorts it, shifts results out row-major
    bvs_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_box     (res_box),
        .o_last    (o_last_result)
    );

    assign o_sorted_id     = res_box.id;
    assign o_sorted_length = res_box.len;
    assign o_sorted_width  = res_box.wid;
    assign o_sorted_height = res_box.hgt;
    assign o_sorted_volume = res_box.vol;

    // credit scheme must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && !q_pop |-> q_count < QCW'(bvs_pkg::QDEPTH))
        else $error("queue overflow");

    // after the final result transfer the engine stops emitting
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_last_result |=> empty)
        else $error("emit continued past last result");

    // engine never takes from the queue while results are pending
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !q_pop)
        else $error("load during emit");

endmodule

### verif/testbench.sv
// Self-checking testbench for the box volume shear sort block.
`timescale 1ns / 1ps

module testbench;

    localparam int SIDE     = bvs_pkg::GRID_SIDE_DEF;
    localparam int NCELL    = SIDE * SIDE;
    localparam int DRAIN    = 200;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] len;
        logic [15:0] wid;
        logic [15:0] hgt;
    } t_load;

    typedef struct packed {
        bvs_pkg::t_box box;
        logic last;
    } t_sorted;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [15:0] i_box_id = '0;
    logic [15:0] i_length = '0;
    logic [15:0] i_width = '0;
    logic [15:0] i_height = '0;
    logic        full, empty, o_last_result;
    logic [15:0] o_sorted_id, o_sorted_length, o_sorted_width, o_sorted_height;
    logic [47:0] o_sorted_volume;

    box_volume_shear_sort u_dut (.*);

    always #5 i_clk = ~i_clk;

    // pending loads, expected sorted boxes, and the model's copy of the grid
    t_load         load_q[$];
    t_sorted       sorted_q[$];
    bvs_pkg::t_box grid[NCELL];
    int      grid_fill = 0;
    int      errors = 0;
    int      idle_pct = 20;        // idle percentage, zero during the quiet stretch
    bit      hold_push = 1'b0;     // sender held off until results drain
    int      quiet_cycles = 0;

    // Ordered compare-exchange: swap when lo must come after hi.
    function automatic bit box_after(bvs_pkg::t_box a, bvs_pkg::t_box b);
        if (a.vol != b.vol) return a.vol > b.vol;
        return a.hgt > b.hgt;
    endfunction

    task automat_exchange(int lo, int hi, bit ascend);
        bvs_pkg::t_box t;
        if (ascend ? box_after(grid[lo], grid[hi]) : box_after(grid[hi], grid[lo])) begin
            t = grid[lo];
            grid[lo] = grid[hi];
            grid[hi] = t;
        end
    endtask

    // Load one box into the model grid; a full grid is shear-sorted and
    // emitted row-major into the expected queue.
    task automatic load_box(t_load b);
        int phases, pw;
        t_sorted s;
        grid[grid_fill].id  = b.id;
        grid[grid_fill].len = b.len;
        grid[grid_fill].wid = b.wid;
        grid[grid_fill].hgt = b.hgt;
        grid[grid_fill].vol = 48'(b.len) * 48'(b.wid) * 48'(b.hgt);
        grid_fill++;
        if (grid_fill < NCELL) return;
        phases = 1;
        pw = 1;
        while (pw < NCELL) begin
            phases++;
            pw = pw << 1;
        end
        for (int p = 0; p < phases; p++) begin
            for (int ln = 0; ln < SIDE; ln++) begin
                for (int st = 0; st < SIDE; st++) begin
                    for (int k = st & 1; k + 1 < SIDE; k += 2) begin
                        if ((p & 1) == 0)
                            automat_exchange(ln * SIDE + k, ln * SIDE + k + 1, (ln & 1) == 0);
                        else
                            automat_exchange(k * SIDE + ln, (k + 1) * SIDE + ln, 1'b1);
                    end
                end
            end
        end
        for (int c = 0; c < NCELL; c++) begin
            s.box  = grid[c];
            s.last = (c == NCELL - 1);
            sorted_q.push_back(s);
        end
        grid_fill = 0;
    endtask

    // Driver: presents the head of the load queue, holds it until transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                load_box(load_q.pop_front());
            end
            if ((!push || !full) ) begin
                if (load_q.size() > 0 && !hold_push && $urandom_range(99) >= idle_pct) begin
                    push     <= 1'b1;
                    i_box_id <= load_q[0].id;
                    i_length <= load_q[0].len;
                    i_width  <= load_q[0].wid;
                    i_height <= load_q[0].hgt;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        t_sorted e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (sorted_q.size() == 0) begin
                    $error("unexpected result id %0h", o_sorted_id);
                    errors++;
                end else begin
                    e = sorted_q.pop_front();
                    if (o_sorted_id !== e.box.id) begin
                        $error("sorted_id exp %0h got %0h", e.box.id, o_sorted_id);
                        errors++;
                    end
                    if (o_sorted_length !== e.box.len) begin
                        $error("sorted_length exp %0h got %0h", e.box.len, o_sorted_length);
                        errors++;
                    end
                    if (o_sorted_width !== e.box.wid) begin
                        $error("sorted_width exp %0h got %0h", e.box.wid, o_sorted_width);
                        errors++;
                    end
                    if (o_sorted_height !== e.box.hgt) begin
                        $error("sorted_height exp %0h got %0h", e.box.hgt, o_sorted_height);
                        errors++;
                    end
                    if (o_sorted_volume !== e.box.vol) begin
                        $error("sorted_volume exp %0h got %0h", e.box.vol, o_sorted_volume);
                        errors++;
                    end
                    if (o_last_result !== e.last) begin
                        $error("last_result exp %0b got %0b", e.last, o_last_result);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: cycles without any transfer.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_load rand_box();
        t_load b;
        b.id = 16'($urandom);
        case ($urandom_range(3))
            0: begin  // small dims crowd the volumes, forcing height tie-breaks
                b.len = 16'($urandom_range(3));
                b.wid = 16'($urandom_range(3));
                b.hgt = 16'($urandom_range(3));
            end
            1: begin  // extremes
                b.len = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                b.wid = $urandom_range(1) ? 16'hFFFF : 16'h0100;
                b.hgt = $urandom_range(1) ? 16'hFFFF : 16'h0001;
            end
            default: begin
                b.len = 16'($urandom);
                b.wid = 16'($urandom);
                b.hgt = 16'($urandom);
            end
        endcase
        return b;
    endfunction

    initial begin
        t_load b;
        // directed grid: extremes, zero volumes, full ties and equal-volume
        // boxes that differ in height, then random filler
        for (int c = 0; c < NCELL; c++) begin
            case (c)
                0: b = t_load'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                1: b = t_load'{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                2: b = t_load'{16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF};
                3: b = t_load'{16'h0002, 16'h0100, 16'h0100, 16'h0100};
                4: b = t_load'{16'h0003, 16'h0100, 16'h0100, 16'h0100};
                5: b = t_load'{16'h0004, 16'h0200, 16'h0100, 16'h0080};
                6: b = t_load'{16'h0005, 16'h0080, 16'h0100, 16'h0200};
                7: b = t_load'{16'h0006, 16'h0100, 16'h0200, 16'h0080};
                8: b = t_load'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
                9: b = t_load'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};
                default: b = (c < 24) ? t_load'{16'(c), 16'h0100, 16'h0100, 16'h0100}
                                      : rand_box();
            endcase
            load_q.push_back(b);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender holds off once until the first run has fully drained
        wait (load_q.size() == 0);
        hold_push = 1'b1;
        for (int c = 0; c < 2 * NCELL; c++) load_q.push_back(rand_box());
        wait (sorted_q.size() == 0);
        @(posedge i_clk);
        hold_push = 1'b0;

        // quiet stretch with no idling, then normal idling again
        wait (load_q.size() < NCELL);
        idle_pct = 0;
        wait (load_q.size() == 0);
        idle_pct = 20;
        for (int c = 0; c < NCELL; c++) load_q.push_back(rand_box());

        wait (load_q.size() == 0 && sorted_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
